/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros
// short forms for clocked concurrent assertions with a synchronous reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequent must hold on the next edge after the antecedent
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/dbavg_pkg.sv */
// ----------------------------------------------------------------------------
// dbavg_pkg
// shared constants for the dual boxcar averager with sample log
// ----------------------------------------------------------------------------
package dbavg_pkg;

  // default sizes
  localparam int WINDOW_DEFAULT    = 100;
  localparam int LOG_DEPTH_DEFAULT = 2048;

  // sample and field widths
  localparam int SAMPLE_BITS = 12;
  localparam int SAMPLE_MAX  = (1 << SAMPLE_BITS) - 1;
  localparam int SUM_W       = 19;
  localparam int COUNT_W     = 12;
  localparam int ENTRY_W     = 12;

  // operation codes carried on s_tuser
  localparam int OP_W = 2;
  localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  // input tdata layout
  localparam int IN_DATA_W = 2 * SAMPLE_BITS;

  // output tdata layout
  localparam int OUT_INT_LSB   = 0;
  localparam int OUT_EXT_LSB   = OUT_INT_LSB + SUM_W;
  localparam int OUT_COUNT_LSB = OUT_EXT_LSB + SUM_W;
  localparam int OUT_ENTRY_LSB = OUT_COUNT_LSB + COUNT_W;
  localparam int OUT_USED_W    = OUT_ENTRY_LSB + ENTRY_W;
  localparam int OUT_DATA_W    = ((OUT_USED_W + 7) / 8) * 8;

  typedef logic [SAMPLE_BITS-1:0] sample_t;

endpackage

/* rtl/dbavg_ram.sv */
// ----------------------------------------------------------------------------
// dbavg_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module dbavg_ram #(
  parameter int WIDTH  = dbavg_pkg::SAMPLE_BITS,
  parameter int DEPTH  = dbavg_pkg::LOG_DEPTH_DEFAULT,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/dual_boxcar_average_with_sample_log_core.sv */
// ----------------------------------------------------------------------------
// dual_boxcar_average_with_sample_log_core
// two boxcar running sums over sample pairs, plus a log of external samples
// ----------------------------------------------------------------------------
// usage
//   input stream s_*: s_tuser carries the operation (add pair, read next log
//   entry, clear log), s_tdata the internal and external samples
//   output stream m_*: one result transaction per input transaction, in order,
//   with both running sums, the log count and, for a read, the entry
//   (m_tuser flags a returned entry, m_tlast marks the newest entry held)
// timing
//   one transaction per cycle sustained while m_tready stays high; a result
//   passes the ram read stage and the output register before m_tvalid shows it
//   the ram read stage serves the ring and log rams: the read issued at accept
//   is registered, and the sum update uses it in the following stage
//   back-to-back hits on one ring entry (window of one) are forwarded
// reset
//   clears sums, pointers and log count; the rings read as zero until the
//   window pointer first wraps, so no clearing pass is needed
// back-pressure
//   a stalled result holds in the output register, one more transaction may
//   wait in the ram read stage, then s_tready drops
// ----------------------------------------------------------------------------
module dual_boxcar_average_with_sample_log_core #(
  parameter int WINDOW    = dbavg_pkg::WINDOW_DEFAULT,
  parameter int LOG_DEPTH = dbavg_pkg::LOG_DEPTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // internal_sample, external_sample
  input  logic [dbavg_pkg::IN_DATA_W-1:0] s_tdata,
  // operation
  input  logic [dbavg_pkg::OP_W-1:0]      s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // internal_sum, external_sum, log_count, log_entry, zero padding
  output logic [dbavg_pkg::OUT_DATA_W-1:0] m_tdata,
  // entry_valid
  output logic                            m_tuser,
  // entry_last
  output logic                            m_tlast
);

  import dbavg_pkg::*;

  localparam int RA_W       = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int LA_W       = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
  localparam int FILL_W     = $clog2(LOG_DEPTH + 1);
  localparam int TOTAL_W    = $clog2(WINDOW * SAMPLE_MAX + 1);
  localparam int TOT_EXT_W  = (TOTAL_W > SUM_W) ? TOTAL_W : SUM_W;
  localparam int FILL_EXT_W = (FILL_W > COUNT_W) ? FILL_W : COUNT_W;

  // input side
  logic    in_accept;
  logic    op_add;
  logic    op_read;
  logic    op_clear;
  sample_t in_int;
  sample_t in_ext;

  // window and log pointers, advanced at accept
  logic [RA_W-1:0]   wp;
  logic [RA_W-1:0]   wp_next;
  logic              wrapped;
  logic [FILL_W-1:0] log_fill;
  logic [FILL_W-1:0] fill_base;
  logic [FILL_W-1:0] fill_after;
  logic [FILL_W-1:0] read_pointer;
  logic [FILL_W-1:0] rp_inc;
  logic              rd_hit;
  logic              rd_last;

  // ram read stage
  logic              s1_valid;
  logic              s1_advance;
  logic              s1_add;
  logic [RA_W-1:0]   s1_addr;
  sample_t           s1_int;
  sample_t           s1_ext;
  logic              s1_wrap;
  logic              s1_fwd;
  sample_t           s1_fwd_int;
  sample_t           s1_fwd_ext;
  logic [FILL_W-1:0] s1_count;
  logic              s1_entry_valid;
  logic              s1_entry_last;

  // ram data
  sample_t ring_int_rdata;
  sample_t ring_ext_rdata;
  sample_t log_rdata;

  // running totals
  logic [TOTAL_W-1:0] int_total;
  logic [TOTAL_W-1:0] ext_total;
  logic [TOTAL_W-1:0] int_total_next;
  logic [TOTAL_W-1:0] ext_total_next;
  sample_t            old_int;
  sample_t            old_ext;

  // output register
  logic               o_valid;
  logic [SUM_W-1:0]   o_int_sum;
  logic [SUM_W-1:0]   o_ext_sum;
  logic [COUNT_W-1:0] o_count;
  logic [ENTRY_W-1:0] o_entry;
  logic               o_entry_valid;
  logic               o_entry_last;

  // -------------------------------------------------------------------------
  // handshake: the read stage moves on when the output register is free
  // -------------------------------------------------------------------------
  assign s1_advance = s1_valid && (!o_valid || m_tready);
  assign s_tready   = !s1_valid || s1_advance;
  assign in_accept  = s_tvalid && s_tready;

  assign op_add   = (s_tuser == OP_ADD);
  assign op_read  = (s_tuser == OP_READ);
  assign op_clear = (s_tuser == OP_CLEAR);
  assign in_int   = s_tdata[SAMPLE_BITS-1:0];
  assign in_ext   = s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];

  // -------------------------------------------------------------------------
  // pointer logic
  // -------------------------------------------------------------------------
  assign wp_next = (wp == RA_W'(WINDOW - 1)) ? '0 : wp + RA_W'(1);

  // a full log restarts at entry zero on the next append
  assign fill_base = (log_fill >= FILL_W'(LOG_DEPTH)) ? '0 : log_fill;
  assign rp_inc    = read_pointer + FILL_W'(1);
  assign rd_hit    = (read_pointer < log_fill);
  assign rd_last   = (rp_inc == log_fill);

  always_comb begin
    fill_after = log_fill;
    if (op_add) begin
      fill_after = fill_base + FILL_W'(1);
    end else if (op_clear) begin
      fill_after = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp           <= '0;
      wrapped      <= 1'b0;
      log_fill     <= '0;
      read_pointer <= '0;
    end else if (in_accept) begin
      log_fill <= fill_after;
      unique case (s_tuser)
        OP_ADD: begin
          wp <= wp_next;
          if (wp == RA_W'(WINDOW - 1)) begin
            wrapped <= 1'b1;
          end
        end
        OP_READ: begin
          if (rd_hit) begin
            read_pointer <= rp_inc;
          end
        end
        OP_CLEAR: begin
          read_pointer <= '0;
        end
        default: begin
          // unused code, nothing moves
        end
      endcase
    end
  end

  // -------------------------------------------------------------------------
  // rams
  // -------------------------------------------------------------------------
  dbavg_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (WINDOW)
  ) u_ring_int (
    .clk   (clk),
    .we    (s1_advance && s1_add),
    .waddr (s1_addr),
    .wdata (s1_int),
    .re    (in_accept && op_add),
    .raddr (wp),
    .rdata (ring_int_rdata)
  );

  dbavg_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (WINDOW)
  ) u_ring_ext (
    .clk   (clk),
    .we    (s1_advance && s1_add),
    .waddr (s1_addr),
    .wdata (s1_ext),
    .re    (in_accept && op_add),
    .raddr (wp),
    .rdata (ring_ext_rdata)
  );

  // log written at accept; a read only reaches entries below the fill count
  dbavg_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (LOG_DEPTH)
  ) u_log (
    .clk   (clk),
    .we    (in_accept && op_add),
    .waddr (fill_base[LA_W-1:0]),
    .wdata (in_ext),
    .re    (in_accept && op_read && rd_hit),
    .raddr (read_pointer[LA_W-1:0]),
    .rdata (log_rdata)
  );

  // -------------------------------------------------------------------------
  // ram read stage
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_add         <= op_add;
      s1_addr        <= wp;
      s1_int         <= in_int;
      s1_ext         <= in_ext;
      s1_wrap        <= wrapped;
      // the entry being written this cycle is the one just read
      s1_fwd         <= s1_valid && s1_add && (s1_addr == wp);
      s1_fwd_int     <= s1_int;
      s1_fwd_ext     <= s1_ext;
      s1_count       <= fill_after;
      s1_entry_valid <= op_read && rd_hit;
      s1_entry_last  <= op_read && rd_hit && rd_last;
    end
  end

  // evicted samples: zero before the first wrap, forwarded on a clash
  always_comb begin
    old_int = '0;
    old_ext = '0;
    if (s1_wrap) begin
      old_int = s1_fwd ? s1_fwd_int : ring_int_rdata;
      old_ext = s1_fwd ? s1_fwd_ext : ring_ext_rdata;
    end
  end

  always_comb begin
    int_total_next = int_total;
    ext_total_next = ext_total;
    if (s1_add) begin
      int_total_next = int_total + TOTAL_W'(s1_int) - TOTAL_W'(old_int);
      ext_total_next = ext_total + TOTAL_W'(s1_ext) - TOTAL_W'(old_ext);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      int_total <= '0;
      ext_total <= '0;
    end else if (s1_advance) begin
      int_total <= int_total_next;
      ext_total <= ext_total_next;
    end
  end

  // -------------------------------------------------------------------------
  // output register
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (s1_advance) begin
      o_valid <= 1'b1;
    end else if (m_tready) begin
      o_valid <= 1'b0;
    end
  end

  // sums and count wrap at their field widths
  always_ff @(posedge clk) begin
    if (s1_advance) begin
      o_int_sum     <= SUM_W'(TOT_EXT_W'(int_total_next));
      o_ext_sum     <= SUM_W'(TOT_EXT_W'(ext_total_next));
      o_count       <= COUNT_W'(FILL_EXT_W'(s1_count));
      o_entry       <= s1_entry_valid ? ENTRY_W'(log_rdata) : '0;
      o_entry_valid <= s1_entry_valid;
      o_entry_last  <= s1_entry_last;
    end
  end

  assign m_tvalid = o_valid;
  assign m_tuser  = o_entry_valid;
  assign m_tlast  = o_entry_last;
  assign m_tdata  = {(OUT_DATA_W - OUT_USED_W)'(0), o_entry, o_count, o_ext_sum, o_int_sum};

endmodule

/* rtl/dbavg_checker.sv */
// ----------------------------------------------------------------------------
// dbavg_port_checker
// port-level checks on the result stream, bound to the core
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dbavg_port_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tvalid,
  input logic                             s_tready,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [dbavg_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic                             m_tuser,
  input logic                             m_tlast
);

  import dbavg_pkg::*;

  logic                    in_take;
  logic                    out_take;
  logic                    entry_zero;
  logic                    pad_zero;
  logic [OUT_DATA_W+1:0]   out_bus;
  logic [2:0]              inflight;

  assign in_take    = s_tvalid && s_tready;
  assign out_take   = m_tvalid && m_tready;
  assign entry_zero = (m_tdata[OUT_ENTRY_LSB +: ENTRY_W] == '0);
  assign pad_zero   = (m_tdata[OUT_DATA_W-1:OUT_USED_W] == '0);
  assign out_bus    = {m_tdata, m_tuser, m_tlast};

  // transactions taken and not yet answered
  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight + 3'(in_take) - 3'(out_take);
    end
  end

  // newest-entry mark only with a returned entry
  `ASSERT_ALWAYS(a_last_needs_entry, clk, rst, !(m_tvalid && m_tlast) || m_tuser, "last without entry")

  // no entry means a zero entry field
  `ASSERT_ALWAYS(a_entry_zero, clk, rst, !(m_tvalid && !m_tuser) || entry_zero, "entry not zero")

  // padding above the fields stays zero
  `ASSERT_ALWAYS(a_pad_zero, clk, rst, !m_tvalid || pad_zero, "padding not zero")

  // a stalled result holds until taken
  `ASSERT_NEXT(a_stall_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(out_bus), "stall changed result")

  // a result needs an unanswered transaction
  `ASSERT_ALWAYS(a_no_phantom, clk, rst, !m_tvalid || (inflight != 3'd0), "result without input")

endmodule

bind dual_boxcar_average_with_sample_log_core dbavg_port_checker u_dbavg_port_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
